// ===== hw/rtl/bba_pkg.sv =====
// Package for the buddy block allocator: fixed sizes, status and mode codes,
// controller states and the search result struct. No dependencies.
package bba_pkg;

    localparam int MAX_ORDER     = 6;
    localparam int SEGMENT_BYTES = 16;
    localparam int ARENA_SEGS    = 1 << MAX_ORDER;
    localparam int LEVELS        = MAX_ORDER + 1;
    localparam int ADDR_W        = 6;
    localparam int LVL_W         = 3;
    localparam int WANT_W        = 4;
    localparam int BYTES_W       = 12;
    localparam int GROUP_W       = 8;
    localparam int GROUP_CNT     = ARENA_SEGS / GROUP_W;
    localparam int SUB_W         = 3;

    typedef logic [ARENA_SEGS-1:0] bba_row_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_MEMORY = 2'd1,
        STATUS_TOO_LARGE = 2'd2,
        STATUS_BAD_FREE  = 2'd3
    } bba_status_t;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } bba_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_CHECK,
        ST_A_RD,
        ST_A_GRP,
        ST_A_PICK,
        ST_A_CLR,
        ST_A_SPLIT,
        ST_A_MARK,
        ST_F_CHECK,
        ST_F_ORD,
        ST_F_RD,
        ST_F_TEST,
        ST_F_SET_RD,
        ST_F_SET,
        ST_RESP
    } bba_state_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] index;
    } bba_ffs_t;

endpackage

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// Buddy block allocator core: one result item per input item, one item in work at a time.
// Allocate: check the order, per tree level searched read, register and search its row, take
// the block, split down to the wanted order, mark, respond. Free: check the mark, fetch the order,
// test each buddy, read and set the merged row, respond. A rejected item goes straight to response.
// Reset (aresetn low, synchronous): whole arena one free block, no segment granted.
// Depends on bba_pkg and bba_first_free.
module buddy_block_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [11:0] request_bytes, [17:12] free_addr, rest zero
    input  logic        s_tuser,  // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [5:0] granted_addr, [8:6] block_order, rest zero
    output logic [1:0]  m_tuser   // [1:0] status
);
    import bba_pkg::*;

    // Free-map: one row per tree level, bit j of row k is the order-k block j
    bba_row_t          row_mem [LEVELS];
    bba_row_t          row_q_reg;
    logic [LVL_W-1:0]  row_q_idx_reg;
    logic              row_q_vld_reg;
    logic [LEVELS-1:0] row_valid_reg;
    logic              row_we;
    logic              row_re;
    logic [LVL_W-1:0]  row_waddr;
    logic [LVL_W-1:0]  row_raddr;
    bba_row_t          row_wdata;
    bba_row_t          row_eff;

    // Order store, with the granted marks acting as its valid bits
    logic [LVL_W-1:0]      order_mem [ARENA_SEGS];
    logic [LVL_W-1:0]      order_q_reg;
    logic                  order_we;
    logic                  order_re;
    logic [ARENA_SEGS-1:0] mark_reg;
    logic [ARENA_SEGS-1:0] mark_next;

    bba_state_t        state_reg, state_next;
    logic [WANT_W-1:0] want_reg, want_next;
    logic [ADDR_W-1:0] faddr_reg, faddr_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  spl_reg, spl_next;
    logic [LVL_W-1:0]  ord_reg, ord_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    bba_row_t          hold_reg, hold_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [LVL_W-1:0]  res_order_reg, res_order_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    bba_ffs_t          ffs;

    // Order of a request: bit length of bytes / SEGMENT_BYTES, by constant compares
    function automatic logic [WANT_W-1:0] want_of(input logic [BYTES_W-1:0] bytes);
        logic [WANT_W-1:0] cnt;
        cnt = '0;
        for (int j = 0; j < BYTES_W; j++) begin
            if (32'(bytes) >= (32'(SEGMENT_BYTES) << j)) begin
                cnt = cnt + WANT_W'(1);
            end
        end
        return cnt;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An unwritten row reads as its reset value: only the top block free
    always_comb begin
        if (row_q_vld_reg) begin
            row_eff = row_q_reg;
        end else if (row_q_idx_reg == LVL_W'(MAX_ORDER)) begin
            row_eff = bba_row_t'(1);
        end else begin
            row_eff = '0;
        end
    end

    bba_first_free u_first_free (
        .aclk  (aclk),
        .row_i (row_eff),
        .ffs_o (ffs)
    );

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re) begin
            row_q_reg     <= row_mem[row_raddr];
            row_q_idx_reg <= row_raddr;
            row_q_vld_reg <= row_valid_reg[row_raddr] || (row_we && row_waddr == row_raddr);
        end
        if (order_we) begin
            order_mem[addr_reg] <= want_reg[LVL_W-1:0];
        end
        if (order_re) begin
            order_q_reg <= order_mem[faddr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            mark_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mark_reg     <= mark_next;
            m_tvalid_reg <= m_tvalid_next;
            if (row_we) begin
                row_valid_reg[row_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        want_reg       <= want_next;
        faddr_reg      <= faddr_next;
        lvl_reg        <= lvl_next;
        spl_reg        <= spl_next;
        ord_reg        <= ord_next;
        addr_reg       <= addr_next;
        hold_reg       <= hold_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_order_reg  <= res_order_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    always_comb begin
        logic [ADDR_W-1:0] bit_idx;
        logic [ADDR_W:0]   low_mask;
        logic [LVL_W-1:0]  ord_c;

        state_next      = state_reg;
        want_next       = want_reg;
        faddr_next      = faddr_reg;
        lvl_next        = lvl_reg;
        spl_next        = spl_reg;
        ord_next        = ord_reg;
        addr_next       = addr_reg;
        hold_next       = hold_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_order_next  = res_order_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mark_next       = mark_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        row_we          = 1'b0;
        row_re          = 1'b0;
        row_waddr       = lvl_reg;
        row_raddr       = lvl_reg;
        row_wdata       = '0;
        order_we        = 1'b0;
        order_re        = 1'b0;
        bit_idx         = addr_reg >> lvl_reg;
        ord_c           = (order_q_reg > LVL_W'(MAX_ORDER)) ? LVL_W'(MAX_ORDER) : order_q_reg;
        low_mask        = ((ADDR_W + 1)'(1) << ord_c) - (ADDR_W + 1)'(1);

        unique case (state_reg)
            ST_IDLE: begin
                // Latch the item and its order
                if (s_tvalid) begin
                    want_next  = want_of(s_tdata[BYTES_W-1:0]);
                    faddr_next = s_tdata[BYTES_W +: ADDR_W];
                    state_next = (s_tuser == MODE_FREE) ? ST_F_CHECK : ST_A_CHECK;
                end
            end
            ST_A_CHECK: begin
                if (want_reg > WANT_W'(MAX_ORDER)) begin
                    res_status_next = STATUS_TOO_LARGE;
                    res_addr_next   = '0;
                    res_order_next  = '0;
                    state_next      = ST_RESP;
                end else begin
                    lvl_next   = want_reg[LVL_W-1:0];
                    state_next = ST_A_RD;
                end
            end
            ST_A_RD: begin
                row_re     = 1'b1;
                state_next = ST_A_GRP;
            end
            ST_A_GRP: begin
                hold_next  = row_eff;
                state_next = ST_A_PICK;
            end
            ST_A_PICK: begin
                if (ffs.found) begin
                    addr_next  = ffs.index << lvl_reg;
                    hold_next  = hold_reg & ~(bba_row_t'(1) << ffs.index);
                    state_next = ST_A_CLR;
                end else if (lvl_reg == LVL_W'(MAX_ORDER)) begin
                    res_status_next = STATUS_NO_MEMORY;
                    res_addr_next   = '0;
                    res_order_next  = '0;
                    state_next      = ST_RESP;
                end else begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = ST_A_RD;
                end
            end
            ST_A_CLR: begin
                // Take the block; levels between held no free block at all
                row_we    = 1'b1;
                row_wdata = hold_reg;
                spl_next  = lvl_reg;
                if (lvl_reg > want_reg[LVL_W-1:0]) begin
                    state_next = ST_A_SPLIT;
                end else begin
                    state_next = ST_A_MARK;
                end
            end
            ST_A_SPLIT: begin
                // Free the upper half one level down, keep the lower half
                row_we    = 1'b1;
                row_waddr = spl_reg - LVL_W'(1);
                row_wdata = bba_row_t'(1) << ((addr_reg >> row_waddr) | ADDR_W'(1));
                spl_next  = spl_reg - LVL_W'(1);
                if (row_waddr == want_reg[LVL_W-1:0]) begin
                    state_next = ST_A_MARK;
                end
            end
            ST_A_MARK: begin
                order_we           = 1'b1;
                mark_next[addr_reg] = 1'b1;
                res_status_next    = STATUS_OK;
                res_addr_next      = addr_reg;
                res_order_next     = want_reg[LVL_W-1:0];
                state_next         = ST_RESP;
            end
            ST_F_CHECK: begin
                if (!mark_reg[faddr_reg]) begin
                    res_status_next = STATUS_BAD_FREE;
                    res_addr_next   = '0;
                    res_order_next  = '0;
                    state_next      = ST_RESP;
                end else begin
                    order_re             = 1'b1;
                    mark_next[faddr_reg] = 1'b0;
                    state_next           = ST_F_ORD;
                end
            end
            ST_F_ORD: begin
                ord_next  = ord_c;
                lvl_next  = ord_c;
                addr_next = faddr_reg & ~low_mask[ADDR_W-1:0];
                state_next = (ord_c < LVL_W'(MAX_ORDER)) ? ST_F_RD : ST_F_SET_RD;
            end
            ST_F_RD: begin
                row_re     = 1'b1;
                state_next = ST_F_TEST;
            end
            ST_F_TEST: begin
                // Merge with the aligned buddy while it is free
                if (row_eff[bit_idx ^ ADDR_W'(1)]) begin
                    row_we    = 1'b1;
                    row_wdata = row_eff & ~(bba_row_t'(1) << (bit_idx ^ ADDR_W'(1)));
                    addr_next = addr_reg & ~(ADDR_W'(1) << lvl_reg);
                    lvl_next  = lvl_reg + LVL_W'(1);
                    state_next = (lvl_next < LVL_W'(MAX_ORDER)) ? ST_F_RD : ST_F_SET_RD;
                end else begin
                    state_next = ST_F_SET_RD;
                end
            end
            ST_F_SET_RD: begin
                row_re     = 1'b1;
                state_next = ST_F_SET;
            end
            ST_F_SET: begin
                row_we          = 1'b1;
                row_wdata       = row_eff | (bba_row_t'(1) << bit_idx);
                res_status_next = STATUS_OK;
                res_addr_next   = '0;
                res_order_next  = ord_reg;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, res_order_reg, res_addr_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // A row is never read in the cycle it is written; other rows may be
    a_row_hazard: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_we && row_re) |-> (row_waddr != row_raddr))
        else $error("row read and write collide");

    // An accepted item always starts work
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted item dropped");

    // A failed item never carries an address or order
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata == 16'd0))
        else $error("failed item carries payload");
`endif

endmodule

// ===== hw/rtl/bba_first_free.sv =====
// Two-stage lowest-set-bit search over one free-map row.
// Depends on bba_pkg.
module bba_first_free (
    input  logic              aclk,
    input  bba_pkg::bba_row_t row_i,
    output bba_pkg::bba_ffs_t ffs_o
);
    import bba_pkg::*;

    logic [GROUP_CNT-1:0]  any_reg;
    logic [SUB_W-1:0]      sub_reg [GROUP_CNT];
    logic [GROUP_CNT-1:0]  any_next;
    logic [SUB_W-1:0]      sub_next [GROUP_CNT];

    // Stage one: per-group any flag and lowest bit within the group
    always_comb begin
        for (int g = 0; g < GROUP_CNT; g++) begin
            any_next[g] = |row_i[g*GROUP_W +: GROUP_W];
            sub_next[g] = '0;
            for (int b = GROUP_W - 1; b >= 0; b--) begin
                if (row_i[g*GROUP_W + b]) begin
                    sub_next[g] = SUB_W'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        any_reg <= any_next;
        for (int g = 0; g < GROUP_CNT; g++) begin
            sub_reg[g] <= sub_next[g];
        end
    end

    // Stage two: pick the lowest group that holds a free bit
    always_comb begin
        ffs_o.found = 1'b0;
        ffs_o.index = '0;
        for (int g = GROUP_CNT - 1; g >= 0; g--) begin
            if (any_reg[g]) begin
                ffs_o.found = 1'b1;
                ffs_o.index = ADDR_W'(g * GROUP_W + int'(sub_reg[g]));
            end
        end
    end

endmodule
